### hw/rtl/ax25hd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 header decoder package
// Shared constants, codes and types for the AX.25 frame header decoder.
// ----------------------------------------------------------------------------
package ax25hd_pkg;

  // Sizing of the frame and address fields.
  localparam int unsigned MaxAddressFields = 10;
  localparam int unsigned MaxFrameLen      = 1024;
  localparam int unsigned AddrCntW         = $clog2(MaxAddressFields + 1);
  localparam int unsigned InfoW            = 10;
  localparam int unsigned InfoLimitRaw     = (MaxFrameLen - 1 > 1023) ? 1023 : MaxFrameLen - 1;
  localparam logic [InfoW-1:0] InfoLimit   = InfoW'(InfoLimitRaw);

  // Byte patterns used by the decoder.
  localparam logic [7:0] SsidMask    = 8'h1E;
  localparam logic [7:0] RepeatedBit = 8'h80;
  localparam logic [7:0] CtrlMask    = 8'b1110_1110;
  localparam logic [7:0] CtrlUi      = 8'b0000_0010;
  localparam logic [7:0] CtrlFrmr    = 8'b1000_0110;
  localparam logic [2:0] LastCharPos = 3'd6;

  // Frame section codes.
  localparam logic [2:0] SEC_ADDR   = 3'd0;
  localparam logic [2:0] SEC_CTRL   = 3'd1;
  localparam logic [2:0] SEC_PID    = 3'd2;
  localparam logic [2:0] SEC_INFO   = 3'd3;
  localparam logic [2:0] SEC_IGNORE = 3'd4;

  // Byte class codes.
  localparam logic [2:0] CLS_CHAR    = 3'd0;
  localparam logic [2:0] CLS_SSID    = 3'd1;
  localparam logic [2:0] CLS_CTRL    = 3'd2;
  localparam logic [2:0] CLS_PID     = 3'd3;
  localparam logic [2:0] CLS_INFO    = 3'd4;
  localparam logic [2:0] CLS_IGNORED = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DEST     = 3'd1;
  localparam logic [2:0] ST_SOURCE   = 3'd2;
  localparam logic [2:0] ST_VIA      = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  // Command/response codes.
  localparam logic [1:0] CR_OLD  = 2'd0;
  localparam logic [1:0] CR_CMD  = 2'd1;
  localparam logic [1:0] CR_RESP = 2'd2;

  // Frame kind codes.
  localparam logic [1:0] FK_NONE  = 2'd0;
  localparam logic [1:0] FK_IUI   = 2'd1;
  localparam logic [1:0] FK_FRMR  = 2'd2;
  localparam logic [1:0] FK_OTHER = 2'd3;

  // Parser state carried from one item to the next.
  typedef struct packed {
    logic [2:0]          byte_in_address;
    logic [AddrCntW-1:0] address_count;
    logic [2:0]          section;
    logic                dest_c_bit;
    logic [1:0]          resp_kind;
    logic [2:0]          error_code;
    logic [1:0]          frame_kind;
    logic [InfoW-1:0]    info_counter;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    byte_in_address: 3'd0,
    address_count:   '0,
    section:         SEC_ADDR,
    dest_c_bit:      1'b0,
    resp_kind:       CR_OLD,
    error_code:      ST_OK,
    frame_kind:      FK_NONE,
    info_counter:    '0
  };

  // Result of decoding one byte.
  typedef struct packed {
    logic [2:0]       byte_class;
    logic [3:0]       address_index;
    logic [7:0]       decoded_value;
    logic [2:0]       status;
    logic [1:0]       cmd_resp;
    logic [3:0]       hop_count;
    logic [InfoW-1:0] info_length;
  } byte_result_t;

  // A callsign character must be a digit, a capital letter or a space.
  function automatic logic char_ok(input logic [6:0] c);
    char_ok = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) || (c == 7'h20);
  endfunction

endpackage

### hw/rtl/ax25hd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 header byte decoder
// Decodes one frame byte against the current parser state and returns the
// result fields together with the next parser state.
// ----------------------------------------------------------------------------
module ax25hd_decode (
  input  logic [7:0]                 frame_byte_i,
  input  logic                       last_byte_i,
  input  ax25hd_pkg::parse_state_t   state_i,
  output ax25hd_pkg::parse_state_t   state_o,
  output ax25hd_pkg::byte_result_t   result_o
);
  import ax25hd_pkg::*;

  parse_state_t      nx;
  logic [2:0]        cls;
  logic [3:0]        idx;
  logic [7:0]        val;
  logic [2:0]        sec_cur;
  logic [2:0]        addr_err;
  logic [AddrCntW-1:0] hops_w;

  always_comb begin
    nx      = state_i;
    cls     = CLS_IGNORED;
    idx     = 4'd0;
    val     = frame_byte_i;
    // A held error forces the rest of the frame to be ignored.
    sec_cur = (state_i.error_code != ST_OK) ? SEC_IGNORE : state_i.section;
    nx.section = sec_cur;

    // Error code for the address currently being parsed.
    if (state_i.address_count == AddrCntW'(0)) begin
      addr_err = ST_DEST;
    end else if (state_i.address_count == AddrCntW'(1)) begin
      addr_err = ST_SOURCE;
    end else begin
      addr_err = ST_VIA;
    end

    unique case (sec_cur)
      SEC_ADDR: begin
        if (state_i.byte_in_address == 3'd0 &&
            state_i.address_count >= AddrCntW'(MaxAddressFields)) begin
          nx.error_code = ST_TOO_MANY;
          nx.section    = SEC_IGNORE;
        end else if (state_i.byte_in_address < LastCharPos) begin
          // Callsign character.
          cls = CLS_CHAR;
          idx = 4'(state_i.address_count);
          if (!frame_byte_i[0] && char_ok(frame_byte_i[7:1])) begin
            val                = {1'b0, frame_byte_i[7:1]};
            nx.byte_in_address = state_i.byte_in_address + 3'd1;
          end else begin
            val           = 8'd0;
            nx.error_code = addr_err;
            nx.section    = SEC_IGNORE;
          end
        end else begin
          // SSID byte closes the address.
          cls                = CLS_SSID;
          idx                = 4'(state_i.address_count);
          val                = (frame_byte_i & SsidMask) >> 1;
          nx.byte_in_address = 3'd0;
          if (state_i.address_count == AddrCntW'(0)) begin
            if (frame_byte_i[0]) begin
              nx.error_code = ST_DEST;
              nx.section    = SEC_IGNORE;
            end else begin
              nx.dest_c_bit    = frame_byte_i[7];
              nx.address_count = AddrCntW'(1);
            end
          end else begin
            if (state_i.address_count == AddrCntW'(1)) begin
              if (state_i.dest_c_bit) begin
                nx.resp_kind = frame_byte_i[7] ? CR_OLD : CR_CMD;
              end else begin
                nx.resp_kind = frame_byte_i[7] ? CR_RESP : CR_OLD;
              end
            end else begin
              val = val | (frame_byte_i & RepeatedBit);
            end
            nx.address_count = state_i.address_count + AddrCntW'(1);
            if (frame_byte_i[0]) begin
              nx.section = SEC_CTRL;
            end
          end
        end
      end
      SEC_CTRL: begin
        cls = CLS_CTRL;
        if (!frame_byte_i[0] || (frame_byte_i & CtrlMask) == CtrlUi) begin
          nx.frame_kind = FK_IUI;
          nx.section    = SEC_PID;
        end else if ((frame_byte_i & CtrlMask) == CtrlFrmr) begin
          nx.frame_kind = FK_FRMR;
          nx.section    = SEC_INFO;
        end else begin
          nx.frame_kind = FK_OTHER;
          nx.section    = SEC_IGNORE;
        end
      end
      SEC_PID: begin
        cls        = CLS_PID;
        nx.section = SEC_INFO;
      end
      SEC_INFO: begin
        cls = CLS_INFO;
        if (state_i.info_counter < InfoLimit) begin
          nx.info_counter = state_i.info_counter + InfoW'(1);
        end
      end
      default: begin
        cls = CLS_IGNORED;
      end
    endcase

    // Frame ended before the header was complete.
    if (last_byte_i && nx.error_code == ST_OK &&
        (nx.section == SEC_ADDR || nx.section == SEC_CTRL || nx.section == SEC_PID)) begin
      nx.error_code = ST_SHORT;
    end

    hops_w = (nx.address_count >= AddrCntW'(2)) ? nx.address_count - AddrCntW'(2) : '0;
  end

  assign state_o                = nx;
  assign result_o.byte_class    = cls;
  assign result_o.address_index = idx;
  assign result_o.decoded_value = val;
  assign result_o.status        = nx.error_code;
  assign result_o.cmd_resp      = nx.resp_kind;
  assign result_o.hop_count     = 4'(hops_w);
  assign result_o.info_length   = nx.info_counter;

endmodule

### hw/rtl/ax25_frame_header_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 frame header decoder
// Parses a raw AX.25 frame one byte per item and reports each byte's class,
// decoded value and the running frame status.
// ----------------------------------------------------------------------------
// Datapath: an accepted item is held in the input register, then decode logic
// writes its result into the result register.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: rst_ni clears the parser state and all valid flags; the parser also
// returns to its reset state after every item marked with tlast.
module ax25_frame_header_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] address_index, [11:4] decoded_value,
                                      // [14:12] status, [16:15] cmd_resp,
                                      // [20:17] hop_count, [30:21] info_length, [31] 0
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_class
  output logic        m_axis_tlast    // frame_end
);
  import ax25hd_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  logic         out_last_q;
  byte_result_t out_res_q;
  parse_state_t state_q;
  parse_state_t state_next;
  byte_result_t res_next;
  logic         advance;

  // The pipeline moves when the result register can take a new item.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  ax25hd_decode u_decode (
    .frame_byte_i (in_byte_q),
    .last_byte_i  (in_last_q),
    .state_i      (state_q),
    .state_o      (state_next),
    .result_o     (res_next)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Parser state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= in_last_q ? StateReset : state_next;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_res_q  <= res_next;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_res_q.byte_class;
  assign m_axis_tdata  = {1'b0, out_res_q.info_length, out_res_q.hop_count,
                          out_res_q.cmd_resp, out_res_q.status,
                          out_res_q.decoded_value, out_res_q.address_index};

  // A held error of any kind always parks the parser.
  a_error_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error_code != ST_OK |-> state_q.section == SEC_IGNORE)
    else $error("error held outside the ignore section");

  // The parser restarts after the last item of a frame.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_last_q) |=>
      (state_q.section == SEC_ADDR && state_q.error_code == ST_OK &&
       state_q.address_count == '0 && state_q.info_counter == '0))
    else $error("parser state not cleared after frame end");

  // The character position never runs past the SSID byte.
  a_char_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_in_address <= LastCharPos)
    else $error("byte position within address out of range");

  // At most eight via hops are ever reported.
  a_hop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:17] <= 4'(MaxAddressFields - 2))
    else $error("hop count out of range");

  // An empty result register never blocks the input side.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while the result register is empty");

endmodule
